FILE: sv/mccr_pkg.sv
// ----------------------------------------------------------------------------
// mccr_pkg: shared types for the map cache clock replacement block
// Request and response payloads, slot status bits, tag entries and
// controller states.
// ----------------------------------------------------------------------------
package mccr_pkg;

   localparam int unsigned SLOT_W = 8;
   localparam int unsigned TAG_W  = 32;

   localparam logic MODE_TOUCH = 1'b0;
   localparam logic MODE_ALLOC = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [SLOT_W-1:0] slot;
      logic              is_write;
      logic [TAG_W-1:0]  new_tag;
      logic              new_kind;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] chosen_slot;
      logic              evicted;
      logic              victim_dirty;
      logic [TAG_W-1:0]  victim_tag;
      logic              victim_kind;
   } rsp_type;

   typedef struct packed {
      logic referenced;
      logic dirty;
   } stat_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic             kind;
   } tag_entry_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SWEEP,
      ST_RESP
   } state_type;

endpackage

FILE: sv/map_cache_clock_replacement_top.sv
// ----------------------------------------------------------------------------
// map_cache_clock_replacement_top: clock replacement slot manager
// Requests arrive on req_valid/req_ready with a req_type payload; mode 0
// touches a slot (reference bit, dirty bit on writes), mode 1 allocates a
// slot by sweeping the clock hand. Each request gives one response on
// rsp_valid/rsp_ready carrying the chosen slot and, once the cache is full,
// the displaced entry's tag, kind and dirty flag.
// A touch passes through ST_RESP and the output register to rsp_valid. An
// allocation passes N set reference bits (N from 0 to SLOTS) before it
// takes a slot; the sweep reads one status entry per cycle
// from the status memory, so the hand advances one slot per cycle.
// One request is in flight at a time; the next is accepted once the
// previous response has moved into the output register.
// After reset the block runs a clearing pass over the status memory with
// req_ready low. Tags and kinds are not cleared.
// While rsp_ready is low the response holds in the output register and the
// block finishes at most one further request before stalling.
// ----------------------------------------------------------------------------
module map_cache_clock_replacement_top #(
   parameter int unsigned SLOTS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mccr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mccr_pkg::rsp_type rsp_data
);

   localparam int unsigned IDX_W = $clog2(SLOTS);
   localparam int unsigned CNT_W = $clog2(SLOTS + 1);

   mccr_pkg::stat_type      stat_wr_en;
   logic [IDX_W-1:0]        stat_wr_addr;
   mccr_pkg::stat_type      stat_wr_data;
   logic [IDX_W-1:0]        stat_rd_addr;
   mccr_pkg::stat_type      stat_rd_data;
   logic                    tag_en;
   logic [IDX_W-1:0]        tag_addr;
   mccr_pkg::tag_entry_type tag_wr_data;
   mccr_pkg::tag_entry_type tag_rd_data;

   logic                    res_valid;
   logic                    res_taken;
   mccr_pkg::rsp_type       res_data;

   logic                    rsp_valid_ff, rsp_valid_in;
   mccr_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   mccr_stat_mem #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_stat_mem (
      .clock   (clock),
      .wr_en   (stat_wr_en),
      .wr_addr (stat_wr_addr),
      .wr_data (stat_wr_data),
      .rd_addr (stat_rd_addr),
      .rd_data (stat_rd_data)
   );

   mccr_tag_mem #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_tag_mem (
      .clock   (clock),
      .en      (tag_en),
      .addr    (tag_addr),
      .wr_data (tag_wr_data),
      .rd_data (tag_rd_data)
   );

   mccr_ctrl #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .res_valid    (res_valid),
      .res_taken    (res_taken),
      .res_data     (res_data),
      .stat_wr_en   (stat_wr_en),
      .stat_wr_addr (stat_wr_addr),
      .stat_wr_data (stat_wr_data),
      .stat_rd_addr (stat_rd_addr),
      .stat_rd_data (stat_rd_data),
      .tag_en       (tag_en),
      .tag_addr     (tag_addr),
      .tag_wr_data  (tag_wr_data),
      .tag_rd_data  (tag_rd_data)
   );

   assign res_taken = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_taken) begin
         rsp_valid_in = res_valid;
         rsp_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_req_during_clear: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("request port open during status clearing");

   a_no_victim_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.evicted |->
         !rsp_data.victim_dirty && rsp_data.victim_tag == '0 && !rsp_data.victim_kind)
      else $error("victim fields set without eviction");

   a_evict_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.evicted |->
         ({24'd0, rsp_data.chosen_slot} < 32'(SLOTS)) || (SLOTS > 256))
      else $error("evicted slot outside the cache");

   a_ready_not_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous still in flight");

endmodule

FILE: sv/mccr_stat_mem.sv
// ----------------------------------------------------------------------------
// mccr_stat_mem: slot status memory
// One write port with per-bit enables, one registered read port.
// ----------------------------------------------------------------------------
module mccr_stat_mem #(
   parameter int unsigned SLOTS = 256,
   parameter int unsigned IDX_W = 8
) (
   input  logic                clock,
   input  mccr_pkg::stat_type  wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  mccr_pkg::stat_type  wr_data,
   input  logic [IDX_W-1:0]    rd_addr,
   output mccr_pkg::stat_type  rd_data
);

   mccr_pkg::stat_type mem [SLOTS];
   mccr_pkg::stat_type rd_data_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (wr_en.referenced) begin
         mem[wr_addr].referenced <= wr_data.referenced;
      end
      if (wr_en.dirty) begin
         mem[wr_addr].dirty <= wr_data.dirty;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/mccr_tag_mem.sv
// ----------------------------------------------------------------------------
// mccr_tag_mem: slot tag and kind memory
// Read-first single port: old entry is read while the new one is written.
// ----------------------------------------------------------------------------
module mccr_tag_mem #(
   parameter int unsigned SLOTS = 256,
   parameter int unsigned IDX_W = 8
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [IDX_W-1:0]            addr,
   input  mccr_pkg::tag_entry_type     wr_data,
   output mccr_pkg::tag_entry_type     rd_data
);

   mccr_pkg::tag_entry_type mem [SLOTS];
   mccr_pkg::tag_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rd_data_ff <= mem[addr];
         mem[addr]  <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/mccr_ctrl.sv
// ----------------------------------------------------------------------------
// mccr_ctrl: clock hand sequencer
// Clears status after reset, applies touches, sweeps the hand with one
// streamed status read per cycle and fills the chosen slot.
// ----------------------------------------------------------------------------
module mccr_ctrl #(
   parameter int unsigned SLOTS = 256,
   parameter int unsigned IDX_W = 8,
   parameter int unsigned CNT_W = 9
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  mccr_pkg::req_type        req_data,
   output logic                     res_valid,
   input  logic                     res_taken,
   output mccr_pkg::rsp_type        res_data,
   output mccr_pkg::stat_type       stat_wr_en,
   output logic [IDX_W-1:0]         stat_wr_addr,
   output mccr_pkg::stat_type       stat_wr_data,
   output logic [IDX_W-1:0]         stat_rd_addr,
   input  mccr_pkg::stat_type       stat_rd_data,
   output logic                     tag_en,
   output logic [IDX_W-1:0]         tag_addr,
   output mccr_pkg::tag_entry_type  tag_wr_data,
   input  mccr_pkg::tag_entry_type  tag_rd_data
);

   localparam int unsigned EXT_W = (IDX_W > mccr_pkg::SLOT_W) ? IDX_W : mccr_pkg::SLOT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);

   mccr_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]    hand_ff, hand_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0]    filled_ff, filled_in;
   mccr_pkg::req_type   req_ff, req_in;
   logic [mccr_pkg::SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic                evicted_ff, evicted_in;
   logic                vdirty_ff, vdirty_in;

   logic [IDX_W-1:0] nxt_pos;
   logic [IDX_W-1:0] nxt_hand;
   logic [EXT_W-1:0] pos_ext;
   logic [EXT_W-1:0] slot_ext;
   logic             in_range;
   logic             full;

   assign nxt_pos  = (pos_ff == LAST_IDX) ? '0 : pos_ff + 1'b1;
   assign nxt_hand = (hand_ff == LAST_IDX) ? '0 : hand_ff + 1'b1;
   assign pos_ext  = EXT_W'(pos_ff);
   assign slot_ext = EXT_W'(req_data.slot);
   assign in_range = ({24'd0, req_data.slot} < 32'(SLOTS));
   assign full     = (filled_ff == FULL_CNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mccr_pkg::ST_CLEAR;
         hand_ff   <= '0;
         filled_ff <= '0;
      end else begin
         state_ff  <= state_in;
         hand_ff   <= hand_in;
         filled_ff <= filled_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      req_ff      <= req_in;
      res_slot_ff <= res_slot_in;
      evicted_ff  <= evicted_in;
      vdirty_ff   <= vdirty_in;
   end

   always_comb begin
      state_in     = state_ff;
      hand_in      = hand_ff;
      pos_in       = pos_ff;
      filled_in    = filled_ff;
      req_in       = req_ff;
      res_slot_in  = res_slot_ff;
      evicted_in   = evicted_ff;
      vdirty_in    = vdirty_ff;
      req_ready    = 1'b0;
      res_valid    = 1'b0;
      stat_wr_en   = '0;
      stat_wr_addr = pos_ff;
      stat_wr_data = '0;
      stat_rd_addr = pos_ff;
      tag_en       = 1'b0;
      tag_addr     = pos_ff;
      tag_wr_data  = '{tag: req_ff.new_tag, kind: req_ff.new_kind};

      res_data.chosen_slot  = res_slot_ff;
      res_data.evicted      = evicted_ff;
      res_data.victim_dirty = vdirty_ff;
      res_data.victim_tag   = evicted_ff ? tag_rd_data.tag : '0;
      res_data.victim_kind  = evicted_ff & tag_rd_data.kind;

      unique case (state_ff)
         mccr_pkg::ST_CLEAR: begin
            stat_wr_en   = '1;
            stat_wr_addr = hand_ff;
            hand_in      = nxt_hand;
            if (hand_ff == LAST_IDX) begin
               state_in = mccr_pkg::ST_IDLE;
            end
         end
         mccr_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            stat_rd_addr = hand_ff;
            if (req_valid) begin
               req_in = req_data;
               if (req_data.mode == mccr_pkg::MODE_TOUCH) begin
                  res_slot_in = req_data.slot;
                  evicted_in  = 1'b0;
                  vdirty_in   = 1'b0;
                  if (in_range) begin
                     stat_wr_en.referenced = 1'b1;
                     stat_wr_en.dirty      = req_data.is_write;
                     stat_wr_addr          = slot_ext[IDX_W-1:0];
                     stat_wr_data          = '{referenced: 1'b1, dirty: 1'b1};
                  end
                  state_in = mccr_pkg::ST_RESP;
               end else begin
                  pos_in   = hand_ff;
                  state_in = mccr_pkg::ST_SWEEP;
               end
            end
         end
         mccr_pkg::ST_SWEEP: begin
            stat_rd_addr = nxt_pos;
            if (stat_rd_data.referenced) begin
               stat_wr_en.referenced = 1'b1;
               pos_in                = nxt_pos;
            end else begin
               stat_wr_en   = '1;
               stat_wr_data = '{referenced: 1'b1, dirty: req_ff.is_write};
               hand_in      = nxt_pos;
               tag_en       = 1'b1;
               res_slot_in  = pos_ext[mccr_pkg::SLOT_W-1:0];
               evicted_in   = full;
               vdirty_in    = full & stat_rd_data.dirty;
               if (!full) begin
                  filled_in = filled_ff + 1'b1;
               end
               state_in = mccr_pkg::ST_RESP;
            end
         end
         mccr_pkg::ST_RESP: begin
            res_valid = 1'b1;
            if (res_taken) begin
               state_in = mccr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mccr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
